// ----- hdl/equirectangular_geo_distance_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the equirectangular distance block
// Each macro expands to a labelled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined. The enclosing module must have i_clk and i_rst_n.
// ---------------------------------------------------------------------------
`ifndef EQUIRECTANGULAR_GEO_DISTANCE_ASSERT_SVH
`define EQUIRECTANGULAR_GEO_DISTANCE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every clock edge out of reset
`define EQGD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("eqgd: invariant violated");

// consequent must hold in the cycle after the antecedent
`define EQGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eqgd: next-cycle check violated");

`else

`define EQGD_ASSERT_ALWAYS(label, cond)
`define EQGD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/eqgd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eqgd_pkg
// Widths, fixed-point constants and shared types of the distance pipeline.
// ---------------------------------------------------------------------------
package eqgd_pkg;

    localparam int ANGLE_FRAC_BITS = 20;
    localparam int DIST_FRAC_BITS  = 16;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int DIST_W = 32;

    // degree to radian: Q32 constant, differences to Q26, mean to Q30
    localparam int DEG_W      = 28;
    localparam int DEG_SHIFT  = ANGLE_FRAC_BITS + 6;
    localparam int MEAN_SHIFT = ANGLE_FRAC_BITS + 3;
    localparam logic signed [DEG_W-1:0] DEG2RAD_Q32 = 28'sd74961321;

    localparam int RAD_W = 32;
    localparam logic signed [RAD_W-1:0] RAD_CLAMP = 32'sd1073741824;

    localparam int ANG_W = 36;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

    localparam int Z_W           = 33;
    localparam int XY_W          = 34;
    localparam int CORDIC_STAGES = 30;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_Q30 [CORDIC_STAGES] = '{
        33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
        33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
        33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
        33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
        33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
        33'sd1023,      33'sd511,       33'sd255,       33'sd127,
        33'sd63,        33'sd31,        33'sd15,        33'sd8,
        33'sd4,         33'sd2
    };

    localparam int T_W         = 33;
    localparam int SUM_W       = 62;
    localparam int SQRT_STAGES = SUM_W / 2;
    localparam int ROOT_W      = SQRT_STAGES;

    localparam int EARTH_W    = 29;
    localparam logic [EARTH_W-1:0] EARTH_R_Q16 = 29'd417530446;
    localparam int DIST_SHIFT = 42 - DIST_FRAC_BITS;

    typedef struct packed {
        logic signed [RAD_W-1:0] dlat;
        logic signed [RAD_W-1:0] dlon;
        logic                    neg;
    } t_carry;

    function automatic logic signed [RAD_W-1:0] clamp_rad(input logic signed [63:0] v);
        if (v > 64'(RAD_CLAMP))
            return RAD_CLAMP;
        if (v < -64'(RAD_CLAMP))
            return -RAD_CLAMP;
        return RAD_W'(v);
    endfunction

endpackage

// ----- hdl/eqgd_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eqgd_front
// Four stages: degree to radian products, rounding and clamping, mean
// latitude reduction to [-pi, pi], folding into [-pi/2, pi/2].
// ---------------------------------------------------------------------------
`include "equirectangular_geo_distance_assert.svh"

module eqgd_front import eqgd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [LAT_W-1:0] i_lat_a,
    input  logic signed [LAT_W-1:0] i_lat_b,
    input  logic signed [LON_W-1:0] i_lon_a,
    input  logic signed [LON_W-1:0] i_lon_b,
    output logic                    o_valid,
    output logic signed [Z_W-1:0]   o_z,
    output t_carry                  o_carry
);

    localparam int PLAT_W = LAT_W + 1 + DEG_W;
    localparam int PLON_W = LON_W + 1 + DEG_W;
    localparam logic signed [PLAT_W-1:0] LAT_HALF  = PLAT_W'(1) <<< (DEG_SHIFT - 1);
    localparam logic signed [PLON_W-1:0] LON_HALF  = PLON_W'(1) <<< (DEG_SHIFT - 1);
    localparam logic signed [PLAT_W-1:0] MEAN_HALF = PLAT_W'(1) <<< (MEAN_SHIFT - 1);

    logic [3:0] r_valid;

    logic signed [LAT_W:0]    w_dlat, w_msum;
    logic signed [LON_W:0]    w_dlon;
    logic signed [PLAT_W-1:0] r_plat, r_pmean, w_lat_q, w_mean_q;
    logic signed [PLON_W-1:0] r_plon, w_lon_q;

    logic signed [ANG_W-1:0] r_mean, r_z1, w_z1;
    logic signed [Z_W-1:0]   r_z2, w_z2;
    logic                    w_neg;
    t_carry                  r_c2, r_c3, r_c4;

    assign w_dlat = (LAT_W+1)'(i_lat_b) - (LAT_W+1)'(i_lat_a);
    assign w_msum = (LAT_W+1)'(i_lat_a) + (LAT_W+1)'(i_lat_b);
    assign w_dlon = (LON_W+1)'(i_lon_b) - (LON_W+1)'(i_lon_a);

    assign w_lat_q  = (r_plat + LAT_HALF) >>> DEG_SHIFT;
    assign w_lon_q  = (r_plon + LON_HALF) >>> DEG_SHIFT;
    assign w_mean_q = (r_pmean + MEAN_HALF) >>> MEAN_SHIFT;

    // |mean| stays below 2*pi, so one add brings it into range
    always_comb begin
        if (r_mean > PI_Q30)
            w_z1 = r_mean - TWO_PI_Q30;
        else if (r_mean < -PI_Q30)
            w_z1 = r_mean + TWO_PI_Q30;
        else
            w_z1 = r_mean;
    end

    always_comb begin
        w_neg = 1'b1;
        if (r_z1 > HALF_PI_Q30)
            w_z2 = Z_W'(PI_Q30 - r_z1);
        else if (r_z1 < -HALF_PI_Q30)
            w_z2 = Z_W'(-PI_Q30 - r_z1);
        else begin
            w_z2  = Z_W'(r_z1);
            w_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plat  <= PLAT_W'(w_dlat) * PLAT_W'(DEG2RAD_Q32);
            r_plon  <= PLON_W'(w_dlon) * PLON_W'(DEG2RAD_Q32);
            r_pmean <= PLAT_W'(w_msum) * PLAT_W'(DEG2RAD_Q32);

            r_c2   <= '{dlat: clamp_rad(64'(w_lat_q)),
                        dlon: clamp_rad(64'(w_lon_q)),
                        neg:  1'b0};
            r_mean <= ANG_W'(w_mean_q);

            r_c3 <= r_c2;
            r_z1 <= w_z1;

            r_c4 <= '{dlat: r_c3.dlat, dlon: r_c3.dlon, neg: w_neg};
            r_z2 <= w_z2;
        end
    end

    assign o_valid = r_valid[3];
    assign o_z     = r_z2;
    assign o_carry = r_c4;

    `EQGD_ASSERT_NEXT(a_front_take, i_valid && i_en, r_valid[0])

endmodule

// ----- hdl/eqgd_cordic.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eqgd_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage. Starts from
// the pre-scaled gain so that x ends as the cosine in Q30.
// ---------------------------------------------------------------------------
`include "equirectangular_geo_distance_assert.svh"

module eqgd_cordic import eqgd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [Z_W-1:0]  i_z,
    input  t_carry                 i_carry,
    output logic                   o_valid,
    output logic signed [XY_W-1:0] o_x,
    output t_carry                 o_carry
);

    logic [CORDIC_STAGES-1:0] r_valid;
    logic signed [XY_W-1:0]   r_x [CORDIC_STAGES];
    logic signed [XY_W-1:0]   r_y [CORDIC_STAGES];
    logic signed [Z_W-1:0]    r_z [CORDIC_STAGES-1];
    t_carry                   r_carry [CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[CORDIC_STAGES-2:0], i_valid};
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [XY_W-1:0] w_x, w_y, w_xs, w_ys;
        logic signed [Z_W-1:0]  w_z;
        t_carry                 w_c;

        if (i == 0) begin : g_first
            assign w_x = CORDIC_GAIN_Q30;
            assign w_y = '0;
            assign w_z = i_z;
            assign w_c = i_carry;
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
            assign w_c = r_carry[i-1];
        end

        assign w_xs = w_x >>> i;
        assign w_ys = w_y >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_carry[i] <= w_c;
                if (!w_z[Z_W-1]) begin
                    r_x[i] <= w_x - w_ys;
                    r_y[i] <= w_y + w_xs;
                end else begin
                    r_x[i] <= w_x + w_ys;
                    r_y[i] <= w_y - w_xs;
                end
            end
        end

        // the residual angle of the last rotation is not needed
        if (i < CORDIC_STAGES - 1) begin : g_angle
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!w_z[Z_W-1])
                        r_z[i] <= w_z - ATAN_Q30[i];
                    else
                        r_z[i] <= w_z + ATAN_Q30[i];
                end
            end
        end
    end

    assign o_valid = r_valid[CORDIC_STAGES-1];
    assign o_x     = r_x[CORDIC_STAGES-1];
    assign o_carry = r_carry[CORDIC_STAGES-1];

    `EQGD_ASSERT_NEXT(a_cordic_frozen, !i_en, $stable(r_valid))

endmodule

// ----- hdl/eqgd_scale.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eqgd_scale
// Applies the cosine sign, scales the longitude difference by the cosine
// and forms the sum of squares in Q52. Five register stages.
// ---------------------------------------------------------------------------
module eqgd_scale import eqgd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [XY_W-1:0] i_x,
    input  t_carry                 i_carry,
    output logic                   o_valid,
    output logic [SUM_W-1:0]       o_sum
);

    localparam int P_W = RAD_W + XY_W;
    localparam int Q_W = 2 * RAD_W;
    localparam int TT_W = 2 * T_W;
    localparam logic signed [P_W-1:0] P_HALF = P_W'(1) <<< 29;

    logic [4:0] r_valid;

    logic signed [XY_W-1:0]  r_c;
    logic signed [RAD_W-1:0] r_dlat, r_dlon;
    logic signed [P_W-1:0]   r_p;
    logic signed [Q_W-1:0]   w_q;
    logic signed [TT_W-1:0]  w_tt;
    logic signed [T_W-1:0]   r_t;
    logic [SUM_W-1:0]        r_q1, r_q2, r_q3, r_tt, r_sum;

    assign w_q  = Q_W'(r_dlat) * Q_W'(r_dlat);
    assign w_tt = TT_W'(r_t) * TT_W'(r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= i_carry.neg ? -i_x : i_x;
            r_dlat <= i_carry.dlat;
            r_dlon <= i_carry.dlon;

            r_p  <= P_W'(r_dlon) * P_W'(r_c);
            r_q1 <= w_q[SUM_W-1:0];

            r_t  <= T_W'((r_p + P_HALF) >>> 30);
            r_q2 <= r_q1;

            r_tt <= w_tt[SUM_W-1:0];
            r_q3 <= r_q2;

            r_sum <= r_q3 + r_tt;
        end
    end

    assign o_valid = r_valid[4];
    assign o_sum   = r_sum;

endmodule

// ----- hdl/eqgd_sqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eqgd_sqrt
// Floor square root, one result bit per register stage (digit-by-digit
// restoring method on a running remainder).
// ---------------------------------------------------------------------------
module eqgd_sqrt import eqgd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQRT_STAGES-1:0] r_valid;
    logic [SUM_W-1:0]       r_rem  [SQRT_STAGES];
    logic [SUM_W-1:0]       r_root [SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[SQRT_STAGES-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
        logic [SUM_W-1:0] w_rem, w_root;
        logic [SUM_W:0]   w_trial;

        if (k == 0) begin : g_first
            assign w_rem  = i_sum;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_trial = {1'b0, w_root} + {1'b0, BIT};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, w_rem} >= w_trial) begin
                    r_rem[k]  <= w_rem - w_trial[SUM_W-1:0];
                    r_root[k] <= (w_root >> 1) + BIT;
                end else begin
                    r_rem[k]  <= w_rem;
                    r_root[k] <= w_root >> 1;
                end
            end
        end
    end

    assign o_valid = r_valid[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ----- hdl/equirectangular_geo_distance.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// equirectangular_geo_distance
// Equirectangular approximation of the distance between two points.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one item holds two latitudes and two longitudes in
//   signed degrees with 20 fraction bits. Output stream m_axis: one item per
//   input item, the distance in km with 16 fraction bits, saturated.
//   From acceptance to m_axis_tvalid an item passes 4 front stages,
//   30 CORDIC stages for the cosine, 5 scaling stages, 31 square root
//   stages and 2 stages for the radius multiply and rounding.
//   Throughput is one item per cycle while not stalled; every stage holds an item.
//   The whole pipeline moves on one enable: it advances while the output
//   register is empty or being taken. When m_axis_tready is low with a
//   result waiting, every stage holds and s_axis_tready drops; nothing is
//   lost or repeated.
//   Synchronous reset clears all valid bits; the pipeline comes up empty and
//   ready in the cycle after reset is released.
// ---------------------------------------------------------------------------
`include "equirectangular_geo_distance_assert.svh"

module equirectangular_geo_distance import eqgd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,   // lat_a[27:0], lat_b[55:28], lon_a[84:56],
                                         // lon_b[113:85], zero[119:114]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata    // distance_km[31:0]
);

    localparam int PROD_W = ROOT_W + EARTH_W;
    localparam logic [PROD_W:0] D_HALF = (PROD_W+1)'(1) << (DIST_SHIFT - 1);
    localparam logic [PROD_W:0] D_MAX  = (PROD_W+1)'({DIST_W{1'b1}});

    logic w_en;

    logic                   w_f_valid, w_c_valid, w_s_valid, w_q_valid;
    logic signed [Z_W-1:0]  w_z;
    t_carry                 w_f_carry, w_c_carry;
    logic signed [XY_W-1:0] w_x;
    logic [SUM_W-1:0]       w_sum;
    logic [ROOT_W-1:0]      w_root;

    logic              r_p_valid, r_out_valid;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W:0]   w_dist;
    logic [DIST_W-1:0] r_out_data;

    assign w_en = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    eqgd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_lat_a (s_axis_tdata[27:0]),
        .i_lat_b (s_axis_tdata[55:28]),
        .i_lon_a (s_axis_tdata[84:56]),
        .i_lon_b (s_axis_tdata[113:85]),
        .o_valid (w_f_valid),
        .o_z     (w_z),
        .o_carry (w_f_carry)
    );

    eqgd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_z     (w_z),
        .i_carry (w_f_carry),
        .o_valid (w_c_valid),
        .o_x     (w_x),
        .o_carry (w_c_carry)
    );

    eqgd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c_valid),
        .i_x     (w_x),
        .i_carry (w_c_carry),
        .o_valid (w_s_valid),
        .o_sum   (w_sum)
    );

    eqgd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_sum   (w_sum),
        .o_valid (w_q_valid),
        .o_root  (w_root)
    );

    assign w_dist = ({1'b0, r_prod} + D_HALF) >> DIST_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid   <= w_q_valid;
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod     <= PROD_W'(w_root) * PROD_W'(EARTH_R_Q16);
            r_out_data <= (w_dist > D_MAX) ? {DIST_W{1'b1}} : w_dist[DIST_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `EQGD_ASSERT_ALWAYS(a_stall_backs_up, !(m_axis_tvalid && !m_axis_tready) || !s_axis_tready)
    `EQGD_ASSERT_NEXT(a_out_from_prod, w_en && r_p_valid, r_out_valid)

endmodule
